// ===== src/websocket_frame_header_parser_assert.svh =====
// Assertion macros for the frame header parser; empty when synthesizing.
`ifndef WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH
`define WEBSOCKET_FRAME_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define WSFHP_ASSERT(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define WSFHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define WSFHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WSFHP_ASSERT(lbl, clk, rst_n, expr, msg)
`define WSFHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define WSFHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/wsfhp_pkg.sv =====
// Shared types and constants of the frame header parser.
package wsfhp_pkg;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_SMALL = 3'd1,
    STAT_MASKED    = 3'd2,
    STAT_TOO_LARGE = 3'd3,
    STAT_TRUNCATED = 3'd4
  } status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // One queue entry: what a single input byte causes downstream.
  typedef struct packed {
    logic        pay_v;
    logic        stat_v;
    logic [7:0]  data;
    logic        fin;
    logic [3:0]  opcode;
    status_t     status;
    logic [63:0] len;
  } rec_t;

endpackage

// ===== src/websocket_frame_header_parser.sv =====
// Receive-side frame header parser: takes buffer bytes, gives payload and status.
//
// Input channel: one buffer byte per transaction (in_data_byte), with
// in_buffer_end set on the buffer's last byte. in_stall rises only when the
// internal queue is full.
// Result channel: payload-byte transactions for the body of an accepted frame,
// and one status transaction (ok, too small, masked, too large, truncated) for
// the buffer's last byte. out_last_result marks the last transaction of a byte.
// cfg_wr_en/cfg_wr_data set the largest accepted payload length (reset 1 MiB);
// write it only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. A last byte that also
// forwards a payload byte gives two results, which the output stage sends one
// after the other; the queue (QUEUE_DEPTH entries) absorbs that and short
// output stalls. A result passes through the queue and then the output register.
// Reset clears the parser, the queue and the output register and restores the
// length limit. While out_stall is high the result register holds and the
// queue fills; once it is full in_stall is raised.
`include "websocket_frame_header_parser_assert.svh"

module websocket_frame_header_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_fin_bit,
  output logic [3:0]  out_frame_opcode,
  output logic [2:0]  out_status,
  output logic [63:0] out_payload_length,
  output logic        out_last_result
);
  import wsfhp_pkg::*;

  rec_t push_rec;
  rec_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  wsfhp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_buffer_end (in_buffer_end),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .push_rec      (push_rec)
  );

  wsfhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  wsfhp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .empty              (q_empty),
    .pop                (pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_payload_byte   (out_payload_byte),
    .out_fin_bit        (out_fin_bit),
    .out_frame_opcode   (out_frame_opcode),
    .out_status         (out_status),
    .out_payload_length (out_payload_length),
    .out_last_result    (out_last_result)
  );

  `WSFHP_ASSERT(a_queue_sane, clk, rst_n, !(q_full && q_empty), "queue both full and empty")
  `WSFHP_ASSERT_IMP(a_status_last, clk, rst_n, out_valid && out_result_kind == KIND_STATUS, out_last_result, "status result not last")
  `WSFHP_ASSERT_IMP(a_small_clean, clk, rst_n, out_valid && out_result_kind == KIND_STATUS && out_status == STAT_TOO_SMALL, out_payload_length == 64'd0 && !out_fin_bit, "too-small status carries header data")
  `WSFHP_ASSERT_NXT(a_end_queued, clk, rst_n, in_valid && !in_stall && in_buffer_end, !q_empty, "buffer end not queued")

endmodule

// ===== src/wsfhp_front.sv =====
// Header parser front end: decodes each byte and queues the results it causes.
module wsfhp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic             in_valid,
  input  logic [7:0]       in_data_byte,
  input  logic             in_buffer_end,
  input  logic             q_full,
  output logic             in_stall,
  output logic             push,
  output wsfhp_pkg::rec_t  push_rec
);
  import wsfhp_pkg::*;

  typedef enum logic [3:0] {
    HS_FIRST = 4'b0001,
    HS_LEN   = 4'b0010,
    HS_EXT   = 4'b0100,
    HS_BODY  = 4'b1000
  } hstate_t;

  typedef enum logic [1:0] {
    REJ_NONE      = 2'd0,
    REJ_MASKED    = 2'd1,
    REJ_TOO_LARGE = 2'd2
  } reject_t;

  localparam logic [6:0]  LEN_EXT16       = 7'd126;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0010_0000;

  hstate_t     state_r, state_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        mask_r, mask_nxt;
  logic [2:0]  ext_r, ext_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] rem_r, rem_nxt;
  reject_t     rej_r, rej_nxt;
  logic [31:0] max_r;
  logic        acc;
  logic        done;
  logic        pay;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    ext_nxt   = ext_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    rej_nxt   = rej_r;
    done      = 1'b0;
    pay       = 1'b0;
    push_rec  = '0;
    if (acc) begin
      case (state_r)
        HS_FIRST: begin
          fin_nxt   = in_data_byte[7];
          op_nxt    = in_data_byte[3:0];
          state_nxt = HS_LEN;
        end
        HS_LEN: begin
          mask_nxt = in_data_byte[7];
          if (in_data_byte[6:0] < LEN_EXT16) begin
            len_nxt = 64'(in_data_byte[6:0]);
            done    = 1'b1;
          end else begin
            len_nxt   = '0;
            // remaining extended bytes minus one: 2 or 8 bytes
            ext_nxt   = (in_data_byte[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
            state_nxt = HS_EXT;
          end
        end
        HS_EXT: begin
          len_nxt = {len_r[55:0], in_data_byte};
          if (ext_r == 3'd0) begin
            done = 1'b1;
          end else begin
            ext_nxt = ext_r - 3'd1;
          end
        end
        HS_BODY: begin
          if (rej_r == REJ_NONE && rem_r != 64'd0) begin
            pay     = 1'b1;
            rem_nxt = rem_r - 64'd1;
          end
        end
        default: begin
          state_nxt = HS_FIRST;
        end
      endcase

      if (done) begin
        state_nxt = HS_BODY;
        rem_nxt   = len_nxt;
        if (mask_nxt) begin
          rej_nxt = REJ_MASKED;
        end else if (len_nxt > {32'd0, max_r}) begin
          rej_nxt = REJ_TOO_LARGE;
        end else begin
          rej_nxt = REJ_NONE;
        end
      end

      push_rec.pay_v  = pay;
      push_rec.stat_v = in_buffer_end;
      push_rec.data   = in_data_byte;
      push_rec.fin    = fin_nxt;
      push_rec.opcode = op_nxt;
      push_rec.len    = len_nxt;
      push_rec.status = STAT_OK;

      if (in_buffer_end) begin
        case (state_nxt)
          HS_FIRST, HS_LEN: begin
            push_rec.status = STAT_TOO_SMALL;
            push_rec.fin    = 1'b0;
            push_rec.opcode = 4'd0;
            push_rec.len    = '0;
          end
          HS_EXT: begin
            push_rec.status = STAT_TRUNCATED;
            push_rec.len    = '0;
          end
          HS_BODY: begin
            if (rej_nxt == REJ_MASKED) begin
              push_rec.status = STAT_MASKED;
            end else if (rej_nxt == REJ_TOO_LARGE) begin
              push_rec.status = STAT_TOO_LARGE;
            end else if (rem_nxt != 64'd0) begin
              push_rec.status = STAT_TRUNCATED;
            end else begin
              push_rec.status = STAT_OK;
            end
          end
          default: begin
            push_rec.status = STAT_TRUNCATED;
          end
        endcase
        // clear the frame for the next buffer
        state_nxt = HS_FIRST;
        fin_nxt   = 1'b0;
        op_nxt    = 4'd0;
        mask_nxt  = 1'b0;
        ext_nxt   = 3'd0;
        len_nxt   = '0;
        rem_nxt   = '0;
        rej_nxt   = REJ_NONE;
      end
    end
  end

  assign push = acc && (pay || in_buffer_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_FIRST;
      fin_r   <= 1'b0;
      op_r    <= 4'd0;
      mask_r  <= 1'b0;
      ext_r   <= 3'd0;
      len_r   <= '0;
      rem_r   <= '0;
      rej_r   <= REJ_NONE;
      max_r   <= MAX_PAYLOAD_RST;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
      ext_r   <= ext_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      rej_r   <= rej_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

endmodule

// ===== src/wsfhp_queue.sv =====
// Short queue of decoded entries between the parser front and the output side.
module wsfhp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wsfhp_pkg::rec_t  push_rec,
  input  logic             pop,
  output wsfhp_pkg::rec_t  head,
  output logic             full,
  output logic             empty
);
  import wsfhp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/wsfhp_back.sv =====
// Output side: expands each queued entry into one or two registered results.
module wsfhp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  wsfhp_pkg::rec_t  head,
  input  logic             empty,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_fin_bit,
  output logic [3:0]       out_frame_opcode,
  output logic [2:0]       out_status,
  output logic [63:0]      out_payload_length,
  output logic             out_last_result
);
  import wsfhp_pkg::*;

  logic        valid_r;
  logic        phase_r, phase_nxt;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic        fin_r;
  logic [3:0]  op_r;
  status_t     stat_r;
  logic [63:0] len_r;
  logic        last_r;
  logic        load;
  logic        emit;
  logic        both;
  logic        emit_stat;

  assign load      = !valid_r || !out_stall;
  assign emit      = load && !empty;
  assign both      = head.pay_v && head.stat_v;
  // status goes out after the payload byte when the entry carries both
  assign emit_stat = head.stat_v && (phase_r || !head.pay_v);
  assign pop       = emit && (phase_r || !both);

  always_comb begin
    phase_nxt = phase_r;
    if (emit) begin
      phase_nxt = phase_r ? 1'b0 : both;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        valid_r <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      fin_r <= head.fin;
      op_r  <= head.opcode;
      len_r <= head.len;
      if (emit_stat) begin
        kind_r <= KIND_STATUS;
        byte_r <= 8'd0;
        stat_r <= head.status;
        last_r <= 1'b1;
      end else begin
        kind_r <= KIND_PAYLOAD;
        byte_r <= head.data;
        stat_r <= STAT_OK;
        last_r <= !head.stat_v;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_result_kind    = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_fin_bit        = fin_r;
  assign out_frame_opcode   = op_r;
  assign out_status         = stat_r;
  assign out_payload_length = len_r;
  assign out_last_result    = last_r;

endmodule
